@@ rtl/debug_uart_register_block_unit_macros.svh @@
// Assertion macros for the debug UART register block.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef DEBUG_UART_REGISTER_BLOCK_UNIT_MACROS_SVH
`define DEBUG_UART_REGISTER_BLOCK_UNIT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define DUR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define DUR_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/dur_pkg.sv @@
// Package for the debug UART register block: request kinds, register offsets,
// status and control bit positions, and the result record. No dependencies.
package dur_pkg;

    localparam int unsigned OFS_W      = 9;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned SIZE_W     = 4;
    localparam int unsigned APB_ADDR_W = 3;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_RX    = 2'd2
    } kind_t;

    localparam logic [OFS_W-1:0] OFS_CTRL   = 9'h000;
    localparam logic [OFS_W-1:0] OFS_MODE   = 9'h004;
    localparam logic [OFS_W-1:0] OFS_IEN    = 9'h008;
    localparam logic [OFS_W-1:0] OFS_IDIS   = 9'h00C;
    localparam logic [OFS_W-1:0] OFS_IMASK  = 9'h010;
    localparam logic [OFS_W-1:0] OFS_STAT   = 9'h014;
    localparam logic [OFS_W-1:0] OFS_RHOLD  = 9'h018;
    localparam logic [OFS_W-1:0] OFS_THOLD  = 9'h01C;
    localparam logic [OFS_W-1:0] OFS_BAUD   = 9'h020;
    localparam logic [OFS_W-1:0] OFS_CID    = 9'h040;
    localparam logic [OFS_W-1:0] OFS_CEXT   = 9'h044;
    localparam logic [OFS_W-1:0] OFS_FILT   = 9'h048;
    localparam logic [OFS_W-1:0] OFS_DMA_LO = 9'h100;
    localparam logic [OFS_W-1:0] OFS_DMA_HI = 9'h124;

    localparam logic [SIZE_W-1:0] BUS_SIZE = 4'd4;
    localparam logic [SIZE_W-1:0] RX_COUNT = 4'd1;

    // APB register index
    localparam logic REG_CHIP_ID     = 1'b0;
    localparam logic REG_CHIP_EXT_ID = 1'b1;

    // status bits
    localparam int unsigned ST_RXRDY   = 0;
    localparam int unsigned ST_TXRDY   = 1;
    localparam int unsigned ST_OVRE    = 5;
    localparam int unsigned ST_TXEMPTY = 9;

    // control bits
    localparam int unsigned CT_RXEN   = 4;
    localparam int unsigned CT_TXEN   = 6;
    localparam int unsigned CT_RSTSTA = 8;

    typedef struct packed {
        logic [WORD_W-1:0] read_word;
        logic              tx_valid;
        logic [CHAR_W-1:0] tx_char;
        logic              access_error;
    } result_t;

endpackage

@@ rtl/debug_uart_register_block_unit.sv @@
// Top level of the debug UART register block: request decode, register state,
// two-entry result buffer and APB identification registers. Uses dur_pkg.
`include "debug_uart_register_block_unit_macros.svh"

// Each request (bus read, bus write or received character) is decoded and
// applied to the register state in the cycle it is accepted; its single result
// goes to the result register, or to the skid register while that is held, so
// one request per cycle is taken unless stalled. A skid register behind the result
// register keeps req_ready high while one result waits; req_ready drops only
// when both hold results. chip_id and chip_ext_id are written over APB at
// byte addresses 0x0 and 0x4 and should be changed only while the block is idle.
module debug_uart_register_block_unit
    import dur_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [1:0]            kind,
    input  logic [OFS_W-1:0]      offset_addr,
    input  logic [WORD_W-1:0]     write_word,
    input  logic [SIZE_W-1:0]     access_size,
    input  logic [CHAR_W-1:0]     rx_char,

    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [WORD_W-1:0]     read_word,
    output logic                  tx_valid,
    output logic [CHAR_W-1:0]     tx_char,
    output logic                  access_error,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]     pwdata,
    output logic [WORD_W-1:0]     prdata,
    output logic                  pready
);

    logic [WORD_W-1:0] chip_id_reg;
    logic [WORD_W-1:0] chip_ext_id_reg;

    logic [WORD_W-1:0] mode_reg,   mode_next;
    logic [WORD_W-1:0] irq_mask_reg, irq_mask_next;
    logic [WORD_W-1:0] baud_reg,   baud_next;
    logic [WORD_W-1:0] filter_reg, filter_next;
    logic [CHAR_W-1:0] rx_hold_reg, rx_hold_next;
    logic              rxrdy_reg,  rxrdy_next;
    logic              txrdy_reg,  txrdy_next;
    logic              ovre_reg,   ovre_next;

    result_t           out_reg, skid_reg, res;
    logic              out_valid_reg, skid_valid_reg;

    logic              accept;
    logic              pop;
    logic              ok;
    logic              cfg_write;
    logic [WORD_W-1:0] status_word;
    logic              tx_out;
    logic              rhold_read;

    assign accept    = req_valid && req_ready;
    assign pop       = out_valid_reg && rsp_ready;
    assign req_ready = !skid_valid_reg;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        status_word             = '0;
        status_word[ST_RXRDY]   = rxrdy_reg;
        status_word[ST_TXRDY]   = txrdy_reg;
        status_word[ST_OVRE]    = ovre_reg;
        status_word[ST_TXEMPTY] = 1'b1;
    end

    // APB identification registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_id_reg     <= '0;
            chip_ext_id_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_CHIP_ID)
                chip_id_reg <= pwdata;
            else
                chip_ext_id_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_CHIP_EXT_ID) ? chip_ext_id_reg : chip_id_reg;

    // request decode and state update
    always_comb
    begin
        mode_next     = mode_reg;
        irq_mask_next = irq_mask_reg;
        baud_next     = baud_reg;
        filter_next   = filter_reg;
        rx_hold_next  = rx_hold_reg;
        rxrdy_next    = rxrdy_reg;
        txrdy_next    = txrdy_reg;
        ovre_next     = ovre_reg;
        res           = '0;
        ok            = 1'b0;

        case (kind)
            KIND_READ:
            begin
                if (access_size == BUS_SIZE)
                begin
                    ok = 1'b1;
                    case (offset_addr)
                        OFS_MODE:  res.read_word = mode_reg;
                        OFS_IMASK: res.read_word = irq_mask_reg;
                        OFS_STAT:  res.read_word = status_word;
                        OFS_RHOLD:
                        begin
                            res.read_word = {{(WORD_W-CHAR_W){1'b0}}, rx_hold_reg};
                            rxrdy_next    = 1'b0;
                        end
                        OFS_BAUD:  res.read_word = baud_reg;
                        OFS_CID:   res.read_word = chip_id_reg;
                        OFS_CEXT:  res.read_word = chip_ext_id_reg;
                        OFS_FILT:  res.read_word = filter_reg;
                        default:   ok = 1'b0;
                    endcase
                end
            end
            KIND_WRITE:
            begin
                if (access_size == BUS_SIZE)
                begin
                    ok = 1'b1;
                    if (offset_addr < OFS_DMA_LO || offset_addr > OFS_DMA_HI)
                    begin
                        case (offset_addr)
                            OFS_CTRL:
                            begin
                                if (write_word[CT_TXEN])
                                    txrdy_next = 1'b1;
                                if (write_word[CT_RSTSTA])
                                    ovre_next = 1'b0;
                            end
                            OFS_MODE:  mode_next     = write_word;
                            OFS_IEN:   irq_mask_next = irq_mask_reg | write_word;
                            OFS_IDIS:  irq_mask_next = irq_mask_reg & ~write_word;
                            OFS_THOLD:
                            begin
                                res.tx_valid = 1'b1;
                                res.tx_char  = write_word[CHAR_W-1:0];
                            end
                            OFS_BAUD:  baud_next     = write_word;
                            OFS_FILT:  filter_next   = write_word;
                            default:   ok = 1'b0;
                        endcase
                    end
                end
            end
            KIND_RX:
            begin
                if (access_size == RX_COUNT)
                begin
                    ok = 1'b1;
                    if (rxrdy_reg)
                        ovre_next = 1'b1;
                    else
                    begin
                        rx_hold_next = rx_char;
                        rxrdy_next   = 1'b1;
                    end
                end
            end
            default:
                ok = 1'b0;
        endcase

        res.access_error = !ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= '0;
            irq_mask_reg <= '0;
            baud_reg     <= '0;
            filter_reg   <= '0;
            rx_hold_reg  <= '0;
            rxrdy_reg    <= 1'b0;
            txrdy_reg    <= 1'b0;
            ovre_reg     <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            irq_mask_reg <= irq_mask_next;
            baud_reg     <= baud_next;
            filter_reg   <= filter_next;
            rx_hold_reg  <= rx_hold_next;
            rxrdy_reg    <= rxrdy_next;
            txrdy_reg    <= txrdy_next;
            ovre_reg     <= ovre_next;
        end
    end

    // result register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (out_valid_reg && !rsp_ready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !rsp_ready)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign read_word    = out_reg.read_word;
    assign tx_valid     = out_reg.tx_valid;
    assign tx_char      = out_reg.tx_char;
    assign access_error = out_reg.access_error;

    assign tx_out     = rsp_valid && tx_valid;
    assign rhold_read = accept && kind == KIND_READ && offset_addr == OFS_RHOLD
                        && access_size == BUS_SIZE;

    `DUR_NEVER(a_skid_without_out, skid_valid_reg && !out_valid_reg, "skid without result")
    `DUR_ASSERT(a_tx_clean, tx_out |-> (!access_error && read_word == '0), "tx result dirty")
    `DUR_ASSERT(a_ovre_rise, $rose(ovre_reg) |-> $past(rxrdy_reg), "overrun with no char")
    `DUR_ASSERT(a_rhold_clears, rhold_read |=> !rxrdy_reg, "holding read left ready set")

endmodule

@@ test/tb.sv @@
// Testbench for debug_uart_register_block_unit: random and directed register,
// transmit and receive requests checked against a behavioral model of the block.
// Depends on dur_pkg and the block's RTL only.
module tb
    import dur_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_RSVD = 2'd3;

    localparam int unsigned ST_FRAME  = 6;
    localparam int unsigned ST_PARE   = 7;
    localparam int unsigned ST_RXBUFF = 12;
    localparam int unsigned CT_RSTRX  = 2;
    localparam int unsigned CT_RSTTX  = 3;
    localparam int unsigned CT_RXDIS  = 5;
    localparam int unsigned CT_TXDIS  = 7;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PRINT_CAP   = 100;

    typedef struct packed {
        logic [1:0]        kind;
        logic [OFS_W-1:0]  offset_addr;
        logic [WORD_W-1:0] write_word;
        logic [SIZE_W-1:0] access_size;
        logic [CHAR_W-1:0] rx_char;
    } uart_req_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    logic [1:0]            kind = '0;
    logic [OFS_W-1:0]      offset_addr = '0;
    logic [WORD_W-1:0]     write_word = '0;
    logic [SIZE_W-1:0]     access_size = '0;
    logic [CHAR_W-1:0]     rx_char = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    logic [WORD_W-1:0]     read_word;
    logic                  tx_valid;
    logic [CHAR_W-1:0]     tx_char;
    logic                  access_error;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [WORD_W-1:0]     pwdata = '0;
    logic [WORD_W-1:0]     prdata;
    logic                  pready;

    debug_uart_register_block_unit dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // register image of the block
    logic [31:0] status_m;
    logic [31:0] mode_m;
    logic [31:0] imask_m;
    logic [7:0]  rx_hold_m;
    logic [31:0] baud_m;
    logic [31:0] filter_m;
    logic        rx_on_m;
    logic        tx_on_m;
    logic [31:0] chip_id_m;
    logic [31:0] chip_ext_m;

    uart_req_t   queued_reqs[$];
    result_t     pending_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned n_mismatch = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results = 0;
    int unsigned n_tx = 0;
    int unsigned n_flagged = 0;
    int unsigned n_overrun = 0;
    int unsigned cycle_cnt = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        n_mismatch++;
        if (n_mismatch <= PRINT_CAP)
            $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    endtask

    function automatic result_t predict_uart_result(input uart_req_t r);
        result_t res;
        logic    ok;
        res = '0;
        ok = 1'b0;
        if (r.kind == KIND_READ && r.access_size == BUS_SIZE)
        begin
            ok = 1'b1;
            case (r.offset_addr)
                OFS_MODE:  res.read_word = mode_m;
                OFS_IMASK: res.read_word = imask_m;
                OFS_STAT:  res.read_word = status_m;
                OFS_RHOLD:
                begin
                    status_m[ST_RXRDY] = 1'b0;
                    res.read_word = {24'd0, rx_hold_m};
                end
                OFS_BAUD:  res.read_word = baud_m;
                OFS_CID:   res.read_word = chip_id_m;
                OFS_CEXT:  res.read_word = chip_ext_m;
                OFS_FILT:  res.read_word = filter_m;
                default:   ok = 1'b0;
            endcase
        end
        else if (r.kind == KIND_WRITE && r.access_size == BUS_SIZE)
        begin
            ok = 1'b1;
            // DMA channel writes are dropped silently
            if (!(r.offset_addr >= OFS_DMA_LO && r.offset_addr <= OFS_DMA_HI))
            begin
                case (r.offset_addr)
                    OFS_CTRL:
                    begin
                        if (r.write_word[CT_RSTRX])
                        begin
                            status_m[ST_RXBUFF] = 1'b0;
                            rx_on_m = 1'b0;
                        end
                        if (r.write_word[CT_RSTTX])
                        begin
                            status_m[ST_TXEMPTY] = 1'b1;
                            tx_on_m = 1'b0;
                        end
                        if (r.write_word[CT_RXEN])
                            rx_on_m = 1'b1;
                        if (r.write_word[CT_RXDIS])
                            rx_on_m = 1'b0;
                        if (r.write_word[CT_TXEN])
                        begin
                            status_m[ST_TXRDY] = 1'b1;
                            tx_on_m = 1'b1;
                        end
                        if (r.write_word[CT_TXDIS])
                            tx_on_m = 1'b0;
                        if (r.write_word[CT_RSTSTA])
                        begin
                            status_m[ST_PARE] = 1'b0;
                            status_m[ST_FRAME] = 1'b0;
                            status_m[ST_OVRE] = 1'b0;
                        end
                    end
                    OFS_MODE:  mode_m = r.write_word;
                    OFS_IEN:   imask_m = imask_m | r.write_word;
                    OFS_IDIS:  imask_m = imask_m & ~r.write_word;
                    OFS_THOLD:
                    begin
                        res.tx_valid = 1'b1;
                        res.tx_char = r.write_word[7:0];
                    end
                    OFS_BAUD:  baud_m = r.write_word;
                    OFS_FILT:  filter_m = r.write_word;
                    default:   ok = 1'b0;
                endcase
            end
        end
        else if (r.kind == KIND_RX && r.access_size == RX_COUNT)
        begin
            ok = 1'b1;
            if (status_m[ST_RXRDY])
            begin
                status_m[ST_OVRE] = 1'b1;
                n_overrun++;
            end
            else
            begin
                rx_hold_m = r.rx_char;
                status_m[ST_RXRDY] = 1'b1;
            end
        end
        res.access_error = ~ok;
        return res;
    endfunction

    function automatic logic [OFS_W-1:0] map_offset(input int unsigned idx);
        case (idx)
            0:       return OFS_CTRL;
            1:       return OFS_MODE;
            2:       return OFS_IEN;
            3:       return OFS_IDIS;
            4:       return OFS_IMASK;
            5:       return OFS_STAT;
            6:       return OFS_RHOLD;
            7:       return OFS_THOLD;
            8:       return OFS_BAUD;
            9:       return OFS_CID;
            10:      return OFS_CEXT;
            default: return OFS_FILT;
        endcase
    endfunction

    function automatic uart_req_t random_uart_req();
        uart_req_t   r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40)
            r.kind = KIND_READ;
        else if (pick < 75)
            r.kind = KIND_WRITE;
        else if (pick < 95)
            r.kind = KIND_RX;
        else
            r.kind = KIND_RSVD;

        pick = $urandom_range(99);
        if (r.kind == KIND_READ && $urandom_range(3) == 0)
            r.offset_addr = OFS_RHOLD;
        else if (pick < 75)
            r.offset_addr = map_offset($urandom_range(11));
        else if (pick < 85)
            r.offset_addr = OFS_DMA_LO + OFS_W'($urandom_range(OFS_DMA_HI - OFS_DMA_LO));
        else
            r.offset_addr = OFS_W'($urandom_range(511));

        r.write_word = $urandom;
        if (r.offset_addr == OFS_CTRL && $urandom_range(2) != 0)
            r.write_word = $urandom_range(511);

        if ($urandom_range(9) == 0 || r.kind == KIND_RSVD)
            r.access_size = SIZE_W'($urandom_range(15));
        else if (r.kind == KIND_RX)
            r.access_size = RX_COUNT;
        else
            r.access_size = BUS_SIZE;

        r.rx_char = CHAR_W'($urandom_range(255));
        return r;
    endfunction

    task automatic push_req(input logic [1:0] k, input logic [OFS_W-1:0] ofs,
                            input logic [31:0] w, input logic [SIZE_W-1:0] sz,
                            input logic [7:0] ch);
        uart_req_t r;
        r.kind = k;
        r.offset_addr = ofs;
        r.write_word = w;
        r.access_size = sz;
        r.rx_char = ch;
        queued_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        while (queued_reqs.size() != 0 || req_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write one id register, then read it back
    task automatic apb_write(input logic idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_CHIP_ID)
            chip_id_m = val;
        else
            chip_ext_m = val;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== val)
            flag_mismatch("prdata readback", prdata, val);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_phase(input int unsigned send_pct, input int unsigned recv_pct,
                             input logic [31:0] cid, input logic [31:0] cext);
        wait_idle();
        apb_write(REG_CHIP_ID, cid);
        apb_write(REG_CHIP_EXT_ID, cext);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    initial
    begin
        status_m = 32'd0;
        status_m[ST_TXEMPTY] = 1'b1;
        mode_m = '0;
        imask_m = '0;
        rx_hold_m = '0;
        baud_m = '0;
        filter_m = '0;
        rx_on_m = 1'b0;
        tx_on_m = 1'b0;
        chip_id_m = '0;
        chip_ext_m = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_phase(28, 50, 32'h0000_0000, 32'hFFFF_FFFF);
        push_req(KIND_WRITE, OFS_MODE,   32'hFFFF_FFFF, BUS_SIZE, 8'h00);
        push_req(KIND_READ,  OFS_MODE,   32'h0,         BUS_SIZE, 8'h00);
        push_req(KIND_WRITE, OFS_IEN,    32'hFFFF_FFFF, BUS_SIZE, 8'h00);
        push_req(KIND_WRITE, OFS_IDIS,   32'h0000_FFFF, BUS_SIZE, 8'h00);
        push_req(KIND_READ,  OFS_IMASK,  32'h0,         BUS_SIZE, 8'h00);
        push_req(KIND_RX,    OFS_CTRL,   32'h0,         RX_COUNT, 8'hFF);
        // second character while ready is still set: overrun
        push_req(KIND_RX,    OFS_CTRL,   32'h0,         RX_COUNT, 8'h00);
        push_req(KIND_READ,  OFS_STAT,   32'h0,         BUS_SIZE, 8'h00);
        push_req(KIND_READ,  OFS_RHOLD,  32'h0,         BUS_SIZE, 8'h00);
        // every control bit at once: disables win, status errors cleared
        push_req(KIND_WRITE, OFS_CTRL,   32'h0000_01FC, BUS_SIZE, 8'h00);
        push_req(KIND_READ,  OFS_STAT,   32'h0,         BUS_SIZE, 8'h00);
        push_req(KIND_WRITE, OFS_THOLD,  32'hFFFF_FFA5, BUS_SIZE, 8'h00);
        push_req(KIND_WRITE, OFS_BAUD,   32'h0,         BUS_SIZE, 8'h00);
        push_req(KIND_WRITE, OFS_FILT,   32'hFFFF_FFFF, BUS_SIZE, 8'h00);
        push_req(KIND_READ,  OFS_FILT,   32'h0,         BUS_SIZE, 8'h00);
        push_req(KIND_READ,  OFS_CID,    32'h0,         BUS_SIZE, 8'h00);
        push_req(KIND_READ,  OFS_CEXT,   32'h0,         BUS_SIZE, 8'h00);
        push_req(KIND_READ,  OFS_DMA_HI - 9'd1, 32'h0,  BUS_SIZE, 8'h00);
        push_req(KIND_WRITE, OFS_DMA_HI, 32'hFFFF_FFFF, BUS_SIZE, 8'h00);
        push_req(KIND_WRITE, OFS_MODE,   32'h1234_5678, 4'd8,     8'h00);
        push_req(KIND_READ,  OFS_MODE,   32'h0,         4'd0,     8'h00);
        push_req(KIND_RX,    OFS_CTRL,   32'h0,         4'd2,     8'h5A);
        push_req(KIND_RSVD,  OFS_MODE,   32'hFFFF_FFFF, 4'hF,     8'hFF);
        push_req(KIND_READ,  9'h1FF,     32'h0,         BUS_SIZE, 8'h00);
        push_req(KIND_WRITE, OFS_STAT,   32'hFFFF_FFFF, BUS_SIZE, 8'h00);
        repeat (225) queued_reqs.push_back(random_uart_req());

        set_phase(50, 28, 32'hFFFF_FFFF, 32'h0000_0000);
        repeat (250) queued_reqs.push_back(random_uart_req());

        set_phase(0, 0, $urandom, $urandom);
        repeat (250) queued_reqs.push_back(random_uart_req());

        wait_idle();
        $display("%0d requests, %0d results over three id settings and idle mixes",
                 n_accepted, n_results);
        $display("%0d characters sent, %0d overruns, %0d flagged accesses, %0d mismatches",
                 n_tx, n_overrun, n_flagged, n_mismatch);
        if (n_mismatch == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // request driver
    always @(posedge clk)
    begin : req_drive
        uart_req_t r;
        result_t   due;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                r = {kind, offset_addr, write_word, access_size, rx_char};
                due = predict_uart_result(r);
                pending_results.push_back(due);
                n_accepted++;
                if (due.tx_valid)
                    n_tx++;
                if (due.access_error)
                    n_flagged++;
            end
            if (!req_valid || req_ready)
            begin
                if (queued_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    r = queued_reqs.pop_front();
                    req_valid <= 1'b1;
                    kind <= r.kind;
                    offset_addr <= r.offset_addr;
                    write_word <= r.write_word;
                    access_size <= r.access_size;
                    rx_char <= r.rx_char;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : rsp_check
        result_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                n_results++;
                if (pending_results.size() == 0)
                    flag_mismatch("result with no request outstanding", read_word, 32'h0);
                else
                begin
                    want = pending_results.pop_front();
                    if (read_word !== want.read_word)
                        flag_mismatch("read_word", read_word, want.read_word);
                    if (tx_valid !== want.tx_valid)
                        flag_mismatch("tx_valid", {31'd0, tx_valid}, {31'd0, want.tx_valid});
                    if (tx_char !== want.tx_char)
                        flag_mismatch("tx_char", {24'd0, tx_char}, {24'd0, want.tx_char});
                    if (access_error !== want.access_error)
                        flag_mismatch("access_error", {31'd0, access_error},
                                      {31'd0, want.access_error});
                end
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout with %0d results still due", pending_results.size());
            $display("tb failed");
            $finish;
        end
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dur_pkg.sv
rtl/debug_uart_register_block_unit.sv
test/tb.sv
